### hw/rtl/mer_pkg.sv
// mer_pkg: shared types and constants for the midpoint ellipse rasterizer
// holds the controller state, the multiplier operand selects, the writeback codes
// and the command and status structs passed between mer_ctrl and mer_datapath
package mer_pkg;

    localparam int AXIS_BITS_DEF  = 9;
    localparam int COORD_BITS_DEF = 11;
    localparam int LIMIT_BITS     = 10;
    localparam int COLOR_BITS     = 32;
    localparam int MASK_BITS      = 4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [MASK_BITS-1:0] MASK_ONE = 4'b0001;
    localparam logic [MASK_BITS-1:0] MASK_ALL = 4'b1111;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SA, ST_SB, ST_SC, ST_SD,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6,
        ST_R0, ST_R1, ST_R2,
        ST_EMIT
    } ctrl_state_t;

    // operand pairs of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,     // a * a
        MUL_BB,     // b * b
        MUL_A2B,    // a^2 * b
        MUL_R1L,    // a^2 * (2y - 1)
        MUL_R1R,    // b^2 * (x + 1)
        MUL_R1X,    // b^2 * (2x + 3)
        MUL_R1Y,    // a^2 * (2 - 2y)
        MUL_SQX,    // (2x + 1)^2
        MUL_SQY,    // (y - 1)^2
        MUL_R2X,    // b^2 * (2x + 2)
        MUL_R2Y,    // a^2 * (3 - 2y)
        MUL_B2T,    // b^2 * tmp
        MUL_A2T,    // a^2 * tmp
        MUL_AB      // a^2 * b^2
    } mul_sel_t;

    // what is done with the registered product
    typedef enum logic [3:0] {
        WB_NONE,
        WB_ASQ,
        WB_BSQ,
        WB_DINIT,
        WB_ACC_LD,
        WB_R1CMP,
        WB_ACC_DEC,
        WB_R1_STEP,
        WB_TMP,
        WB_ACC_ADD,
        WB_R2_INIT,
        WB_ACC_R2,
        WB_R2_STEP
    } wb_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        wb_op_t   wb_op;
        logic     load;
        logic     first;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic r1_hit;
        logic in_r2;
        logic done;
    } dp_status_t;

endpackage

### hw/rtl/mer_ctrl.sv
// mer_ctrl: sequencer for the ellipse rasterizer
// walks the multiply and writeback schedule of one item; depends on mer_pkg
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  logic                kind,
    input  logic                out_free,
    input  mer_pkg::dp_status_t status,
    output logic                s_ready,
    output mer_pkg::dp_cmd_t    cmd
);
    import mer_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        busy_reg, busy_next;
    logic        first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        first_next = first_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (kind == KIND_START)
                    begin
                        state_next = ST_SA;
                        first_next = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        state_next = status.in_r2 ? ST_R0 : ST_T0;
                        first_next = 1'b0;
                    end
                end
            end
            ST_SA: state_next = ST_SB;
            ST_SB: state_next = ST_SC;
            ST_SC: state_next = ST_SD;
            ST_SD: state_next = ST_EMIT;
            ST_T0: state_next = ST_T1;
            ST_T1: state_next = ST_T2;
            ST_T2: state_next = ST_T3;
            ST_T3: state_next = status.r1_hit ? ST_T4 : ST_Q0;
            ST_T4: state_next = ST_EMIT;
            ST_Q0: state_next = ST_Q1;
            ST_Q1: state_next = ST_Q2;
            ST_Q2: state_next = ST_Q3;
            ST_Q3: state_next = ST_Q4;
            ST_Q4: state_next = ST_Q5;
            ST_Q5: state_next = ST_Q6;
            ST_Q6: state_next = ST_R0;
            ST_R0: state_next = ST_R1;
            ST_R1: state_next = ST_R2;
            ST_R2: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    busy_next  = !status.done;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_ready     = 1'b0;
        cmd.mul_sel = MUL_NONE;
        cmd.wb_op   = WB_NONE;
        cmd.load    = 1'b0;
        cmd.first   = first_reg;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = s_valid && (kind == KIND_START);
            end
            ST_SA: cmd.mul_sel = MUL_AA;
            ST_SB:
            begin
                cmd.mul_sel = MUL_BB;
                cmd.wb_op   = WB_ASQ;
            end
            ST_SC:
            begin
                cmd.mul_sel = MUL_A2B;
                cmd.wb_op   = WB_BSQ;
            end
            ST_SD: cmd.wb_op = WB_DINIT;
            ST_T0: cmd.mul_sel = MUL_R1L;
            ST_T1:
            begin
                cmd.mul_sel = MUL_R1R;
                cmd.wb_op   = WB_ACC_LD;
            end
            ST_T2:
            begin
                cmd.mul_sel = MUL_R1X;
                cmd.wb_op   = WB_R1CMP;
            end
            ST_T3:
            begin
                // region 1 continues, or start building the region 2 decision
                if (status.r1_hit)
                begin
                    cmd.mul_sel = MUL_R1Y;
                    cmd.wb_op   = WB_ACC_DEC;
                end
                else
                begin
                    cmd.mul_sel = MUL_SQX;
                end
            end
            ST_T4: cmd.wb_op = WB_R1_STEP;
            ST_Q0: cmd.wb_op = WB_TMP;
            ST_Q1: cmd.mul_sel = MUL_B2T;
            ST_Q2:
            begin
                cmd.mul_sel = MUL_SQY;
                cmd.wb_op   = WB_ACC_LD;
            end
            ST_Q3: cmd.wb_op = WB_TMP;
            ST_Q4: cmd.mul_sel = MUL_A2T;
            ST_Q5:
            begin
                cmd.mul_sel = MUL_AB;
                cmd.wb_op   = WB_ACC_ADD;
            end
            ST_Q6: cmd.wb_op = WB_R2_INIT;
            ST_R0: cmd.mul_sel = MUL_R2X;
            ST_R1:
            begin
                cmd.mul_sel = MUL_R2Y;
                cmd.wb_op   = WB_ACC_R2;
            end
            ST_R2: cmd.wb_op = WB_R2_STEP;
            ST_EMIT: cmd.emit = out_free;
            default: s_ready = 1'b0;
        endcase
    end

endmodule

### hw/rtl/mer_datapath.sv
// mer_datapath: ellipse state, shared multiplier, decision accumulator and point math
// driven by mer_ctrl through dp_cmd_t; depends on mer_pkg
module mer_datapath #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mer_pkg::dp_cmd_t                  cmd,
    output mer_pkg::dp_status_t               status,
    input  logic signed [COORD_BITS-1:0]      center_x,
    input  logic signed [COORD_BITS-1:0]      center_y,
    input  logic [AXIS_BITS-1:0]              semi_a,
    input  logic [AXIS_BITS-1:0]              semi_b,
    input  logic [mer_pkg::LIMIT_BITS-1:0]    step_limit,
    input  logic                              mirror,
    input  logic [mer_pkg::COLOR_BITS-1:0]    color,
    output logic signed [COORD_BITS:0]        px0,
    output logic signed [COORD_BITS:0]        py0,
    output logic signed [COORD_BITS:0]        px1,
    output logic signed [COORD_BITS:0]        py1,
    output logic signed [COORD_BITS:0]        px2,
    output logic signed [COORD_BITS:0]        py2,
    output logic signed [COORD_BITS:0]        px3,
    output logic signed [COORD_BITS:0]        py3,
    output logic [mer_pkg::MASK_BITS-1:0]     pixel_mask,
    output logic [mer_pkg::COLOR_BITS-1:0]    pixel_color,
    output logic                              done_res
);
    import mer_pkg::*;

    localparam int XB  = LIMIT_BITS;
    localparam int QB  = 2 * AXIS_BITS;
    localparam int MA  = ((QB > XB + 1) ? QB : XB + 1) + 1;
    localparam int MB  = ((2 * XB + 3) > (QB + 1)) ? 2 * XB + 3 : QB + 1;
    localparam int PB  = MA + MB;
    localparam int DB  = QB + 2 * XB + 10;
    localparam int TB  = MB - 1;
    localparam int OB  = COORD_BITS + 1;
    localparam int SM  = (COORD_BITS > XB) ? COORD_BITS : XB;
    localparam int SB  = ((SM > AXIS_BITS) ? SM : AXIS_BITS) + 2;

    logic signed [COORD_BITS-1:0] org_x_reg, org_x_next;
    logic signed [COORD_BITS-1:0] org_y_reg, org_y_next;
    logic [AXIS_BITS-1:0]         axis_a_reg, axis_a_next;
    logic [AXIS_BITS-1:0]         axis_b_reg, axis_b_next;
    logic [QB-1:0]                a_sq_reg, a_sq_next;
    logic [QB-1:0]                b_sq_reg, b_sq_next;
    logic [XB-1:0]                step_x_reg, step_x_next;
    logic [AXIS_BITS-1:0]         step_y_reg, step_y_next;
    logic signed [DB-1:0]         dec_reg, dec_next;
    logic signed [DB-1:0]         acc_reg, acc_next;
    logic [TB-1:0]                tmp_reg, tmp_next;
    logic signed [PB-1:0]         prod_reg, prod_next;
    logic                         r1_hit_reg, r1_hit_next;
    logic                         in_r2_reg, in_r2_next;
    logic [LIMIT_BITS-1:0]        steps_reg, steps_next;
    logic [LIMIT_BITS-1:0]        limit_reg, limit_next;
    logic                         mirror_reg, mirror_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;

    logic signed [MA-1:0] opa;
    logic signed [MB-1:0] opb;
    logic signed [MB-1:0] xe;
    logic signed [MB-1:0] ye;
    logic signed [MA-1:0] a_sq_a;
    logic signed [MA-1:0] b_sq_a;
    logic signed [DB-1:0] pd;
    logic signed [DB-1:0] pd2;
    logic signed [DB-1:0] pd4;
    logic signed [DB-1:0] a_sq_d;
    logic signed [DB-1:0] b_sq_d;
    logic                 dec_neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            axis_a_reg <= '0;
            axis_b_reg <= '0;
            a_sq_reg   <= '0;
            b_sq_reg   <= '0;
            step_x_reg <= '0;
            step_y_reg <= '0;
            dec_reg    <= '0;
            acc_reg    <= '0;
            tmp_reg    <= '0;
            prod_reg   <= '0;
            r1_hit_reg <= 1'b0;
            in_r2_reg  <= 1'b0;
            steps_reg  <= '0;
            limit_reg  <= '0;
            mirror_reg <= 1'b0;
            color_reg  <= '0;
        end
        else
        begin
            org_x_reg  <= org_x_next;
            org_y_reg  <= org_y_next;
            axis_a_reg <= axis_a_next;
            axis_b_reg <= axis_b_next;
            a_sq_reg   <= a_sq_next;
            b_sq_reg   <= b_sq_next;
            step_x_reg <= step_x_next;
            step_y_reg <= step_y_next;
            dec_reg    <= dec_next;
            acc_reg    <= acc_next;
            tmp_reg    <= tmp_next;
            prod_reg   <= prod_next;
            r1_hit_reg <= r1_hit_next;
            in_r2_reg  <= in_r2_next;
            steps_reg  <= steps_next;
            limit_reg  <= limit_next;
            mirror_reg <= mirror_next;
            color_reg  <= color_next;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        xe     = signed'(MB'(step_x_reg));
        ye     = signed'(MB'(step_y_reg));
        a_sq_a = signed'(MA'(a_sq_reg));
        b_sq_a = signed'(MA'(b_sq_reg));
        opa    = '0;
        opb    = '0;
        case (cmd.mul_sel)
            MUL_AA:
            begin
                opa = signed'(MA'(axis_a_reg));
                opb = signed'(MB'(axis_a_reg));
            end
            MUL_BB:
            begin
                opa = signed'(MA'(axis_b_reg));
                opb = signed'(MB'(axis_b_reg));
            end
            MUL_A2B:
            begin
                opa = a_sq_a;
                opb = signed'(MB'(axis_b_reg));
            end
            MUL_R1L:
            begin
                opa = a_sq_a;
                opb = (ye <<< 1) - MB'(1);
            end
            MUL_R1R:
            begin
                opa = b_sq_a;
                opb = xe + MB'(1);
            end
            MUL_R1X:
            begin
                opa = b_sq_a;
                opb = (xe <<< 1) + MB'(3);
            end
            MUL_R1Y:
            begin
                opa = a_sq_a;
                opb = MB'(2) - (ye <<< 1);
            end
            MUL_SQX:
            begin
                opa = signed'(MA'({step_x_reg, 1'b1}));
                opb = signed'(MB'({step_x_reg, 1'b1}));
            end
            MUL_SQY:
            begin
                opa = signed'(MA'(step_y_reg)) - MA'(1);
                opb = ye - MB'(1);
            end
            MUL_R2X:
            begin
                opa = b_sq_a;
                opb = (xe <<< 1) + MB'(2);
            end
            MUL_R2Y:
            begin
                opa = a_sq_a;
                opb = MB'(3) - (ye <<< 1);
            end
            MUL_B2T:
            begin
                opa = b_sq_a;
                opb = signed'(MB'(tmp_reg));
            end
            MUL_A2T:
            begin
                opa = a_sq_a;
                opb = signed'(MB'(tmp_reg));
            end
            MUL_AB:
            begin
                opa = a_sq_a;
                opb = signed'(MB'(b_sq_reg));
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        prod_next = PB'(opa) * PB'(opb);
    end

    assign pd      = DB'(prod_reg);
    assign pd2     = pd <<< 1;
    assign pd4     = pd <<< 2;
    assign a_sq_d  = signed'(DB'(a_sq_reg));
    assign b_sq_d  = signed'(DB'(b_sq_reg));
    assign dec_neg = dec_reg[DB-1];

    // writeback of the registered product and start-item load
    always_comb
    begin
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        axis_a_next = axis_a_reg;
        axis_b_next = axis_b_reg;
        a_sq_next   = a_sq_reg;
        b_sq_next   = b_sq_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        dec_next    = dec_reg;
        acc_next    = acc_reg;
        tmp_next    = tmp_reg;
        r1_hit_next = r1_hit_reg;
        in_r2_next  = in_r2_reg;
        steps_next  = steps_reg;
        limit_next  = limit_reg;
        mirror_next = mirror_reg;
        color_next  = color_reg;
        case (cmd.wb_op)
            WB_ASQ:    a_sq_next = prod_reg[QB-1:0];
            WB_BSQ:    b_sq_next = prod_reg[QB-1:0];
            // 4b^2 - 4a^2 b + a^2
            WB_DINIT:  dec_next = (b_sq_d <<< 2) + a_sq_d - pd4;
            WB_ACC_LD: acc_next = pd;
            // a^2 (2y - 1) > 2 b^2 (x + 1) keeps region 1
            WB_R1CMP:  r1_hit_next = (acc_reg > pd2);
            WB_ACC_DEC: acc_next = dec_reg + pd4;
            WB_R1_STEP:
            begin
                dec_next    = dec_neg ? acc_reg : acc_reg + pd4;
                step_y_next = dec_neg ? step_y_reg : step_y_reg - AXIS_BITS'(1);
                step_x_next = step_x_reg + XB'(1);
                steps_next  = steps_reg + LIMIT_BITS'(1);
            end
            WB_TMP:     tmp_next = prod_reg[TB-1:0];
            WB_ACC_ADD: acc_next = acc_reg + pd4;
            WB_R2_INIT:
            begin
                dec_next   = acc_reg - pd4;
                in_r2_next = 1'b1;
            end
            WB_ACC_R2:  acc_next = dec_neg ? dec_reg + pd4 : dec_reg;
            WB_R2_STEP:
            begin
                dec_next    = acc_reg + pd4;
                step_y_next = step_y_reg - AXIS_BITS'(1);
                step_x_next = dec_neg ? step_x_reg + XB'(1) : step_x_reg;
                steps_next  = steps_reg + LIMIT_BITS'(1);
            end
            default:    dec_next = dec_reg;
        endcase
        if (cmd.load)
        begin
            org_x_next  = center_x;
            org_y_next  = center_y;
            axis_a_next = semi_a;
            axis_b_next = semi_b;
            step_x_next = '0;
            step_y_next = semi_b;
            in_r2_next  = 1'b0;
            steps_next  = '0;
            limit_next  = step_limit;
            mirror_next = mirror;
            color_next  = color;
        end
    end

    assign status.r1_hit = r1_hit_reg;
    assign status.in_r2  = in_r2_reg;
    assign status.done   = !((steps_reg < limit_reg) && (step_y_reg != '0));

    // point coordinates, v = b - y
    logic [AXIS_BITS-1:0] v;
    logic signed [SB-1:0] cx, cy, xs, vs;
    logic signed [SB-1:0] x_pos, x_neg, y_pos, y_neg;
    logic                 all_four;

    always_comb
    begin
        v        = axis_b_reg - step_y_reg;
        cx       = SB'(org_x_reg);
        cy       = SB'(org_y_reg);
        xs       = signed'(SB'(step_x_reg));
        vs       = signed'(SB'(v));
        x_pos    = cx + xs;
        x_neg    = cx - xs;
        y_pos    = cy + vs;
        y_neg    = cy - vs;
        all_four = mirror_reg && !cmd.first;

        px0 = x_pos[OB-1:0];
        py0 = y_pos[OB-1:0];
        px1 = '0;
        py1 = '0;
        px2 = '0;
        py2 = '0;
        px3 = '0;
        py3 = '0;
        pixel_mask = MASK_ONE;
        if (all_four)
        begin
            px1 = x_pos[OB-1:0];
            py1 = y_neg[OB-1:0];
            px2 = x_neg[OB-1:0];
            py2 = y_neg[OB-1:0];
            px3 = x_neg[OB-1:0];
            py3 = y_pos[OB-1:0];
            pixel_mask = MASK_ALL;
        end
        pixel_color = color_reg;
        done_res    = status.done;
    end

endmodule

### hw/rtl/midpoint_ellipse_raster_core.sv
// Midpoint ellipse rasterizer core. A start item (tuser = 0) loads the center, semi-axes,
// step limit, mirror mode and color and returns the first point, the center itself; each
// tick item (tuser = 1) runs one midpoint step and returns the new point, alone or mirrored
// four ways, with tlast set on the last point. Ticks arriving with no ellipse running are
// taken and dropped. One item is in flight at a time: the next item is taken only once the
// sequencer is back in idle. A start runs the S steps, a region 1 tick the T steps, a region 2
// tick the R steps, and the tick that moves to region 2 runs T, then Q to re-seed, then R.
// The steps share the single multiplier with a registered product, used once per cycle at most.
// The result sits in an output register, so the next item is taken while it waits.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
module midpoint_ellipse_raster_core #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    localparam int S_USED = 2 * COORD_BITS + 2 * AXIS_BITS + mer_pkg::LIMIT_BITS + 1
                            + mer_pkg::COLOR_BITS,
    localparam int S_BITS = ((S_USED + 7) / 8) * 8,
    localparam int M_USED = 8 * (COORD_BITS + 1) + mer_pkg::MASK_BITS + mer_pkg::COLOR_BITS,
    localparam int M_BITS = ((M_USED + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // center_x, center_y, semi_a, semi_b, step_limit, mirror, color, zero pad
    input  logic [S_BITS-1:0] s_tdata,
    // kind
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // px0, py0, px1, py1, px2, py2, px3, py3, pixel_mask, pixel_color, zero pad
    output logic [M_BITS-1:0] m_tdata,
    // done_res
    output logic              m_tlast
);
    import mer_pkg::*;

    localparam int OB     = COORD_BITS + 1;
    localparam int O_CY   = COORD_BITS;
    localparam int O_A    = 2 * COORD_BITS;
    localparam int O_B    = O_A + AXIS_BITS;
    localparam int O_LIM  = O_B + AXIS_BITS;
    localparam int O_MIR  = O_LIM + LIMIT_BITS;
    localparam int O_COL  = O_MIR + 1;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_free;

    logic signed [OB-1:0]   px0, py0, px1, py1, px2, py2, px3, py3;
    logic [MASK_BITS-1:0]   pixel_mask;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   done_res;

    logic                   m_valid_reg, m_valid_next;
    logic [M_USED-1:0]      res_reg, res_next;
    logic                   last_reg, last_next;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_tvalid),
        .kind     (s_tuser),
        .out_free (out_free),
        .status   (status),
        .s_ready  (s_tready),
        .cmd      (cmd)
    );

    mer_datapath #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .center_x    (s_tdata[O_CY-1:0]),
        .center_y    (s_tdata[O_A-1:O_CY]),
        .semi_a      (s_tdata[O_B-1:O_A]),
        .semi_b      (s_tdata[O_LIM-1:O_B]),
        .step_limit  (s_tdata[O_MIR-1:O_LIM]),
        .mirror      (s_tdata[O_MIR]),
        .color       (s_tdata[O_COL+COLOR_BITS-1:O_COL]),
        .px0         (px0),
        .py0         (py0),
        .px1         (px1),
        .py1         (py1),
        .px2         (px2),
        .py2         (py2),
        .px3         (px3),
        .py3         (py3),
        .pixel_mask  (pixel_mask),
        .pixel_color (pixel_color),
        .done_res    (done_res)
    );

    // output register slot
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        last_next    = last_reg;
        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
            res_next     = {pixel_color, pixel_mask, py3, px3, py2, px2, py1, px1, py0, px0};
            last_next    = done_res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            res_reg     <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            res_reg     <= res_next;
            last_reg    <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_BITS'(res_reg);
    assign m_tlast  = last_reg;

endmodule

### tb/sv/tb_midpoint_ellipse_raster_core.sv
`timescale 1ns / 1ps
// testbench for midpoint_ellipse_raster_core: random and directed ellipses against a built-in
// step-by-step predictor of the rasterizer, with random sender gaps and receiver stalls
// depends on mer_pkg and the rasterizer rtl
module tb_midpoint_ellipse_raster_core;
    import mer_pkg::*;

    localparam int AXIS_BITS  = 9;
    localparam int COORD_BITS = 11;
    localparam int S_BITS = ((2 * COORD_BITS + 2 * AXIS_BITS + LIMIT_BITS + 1 + COLOR_BITS + 7)
                            / 8) * 8;
    localparam int M_BITS = ((8 * (COORD_BITS + 1) + MASK_BITS + COLOR_BITS + 7) / 8) * 8;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] color;
        logic [3:0]  mask;
        logic [11:0] py3;
        logic [11:0] px3;
        logic [11:0] py2;
        logic [11:0] px2;
        logic [11:0] py1;
        logic [11:0] px1;
        logic [11:0] py0;
        logic [11:0] px0;
    } point_word_t;

    typedef struct packed {
        logic        done;
        point_word_t word;
    } raster_point_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;
    logic              m_tlast;

    midpoint_ellipse_raster_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // predictor state of the ellipse being traced
    longint org_x, org_y, a_sq, b_sq, axis_b, cur_x, cur_y, dec_val;
    bit     in_r2;
    int     steps_taken, step_cap;
    bit     mirror_on;
    logic [31:0] color_hold;
    bit     tracing;

    raster_point_t pending_points[$];
    int errors;
    int items_sent;
    int burst_left;
    int gap_max;
    int hold_cycles;

    function automatic bit trace_finished();
        return !(steps_taken < step_cap && cur_y > 0);
    endfunction

    task automatic push_point(input bit first, input bit done);
        raster_point_t p;
        longint v;
        v = axis_b - cur_y;
        p = '0;
        p.word.px0 = 12'(org_x + cur_x);
        p.word.py0 = 12'(org_y + v);
        if (mirror_on && !first)
        begin
            p.word.px1 = 12'(org_x + cur_x);
            p.word.py1 = 12'(org_y - v);
            p.word.px2 = 12'(org_x - cur_x);
            p.word.py2 = 12'(org_y - v);
            p.word.px3 = 12'(org_x - cur_x);
            p.word.py3 = 12'(org_y + v);
            p.word.mask = MASK_ALL;
        end
        else
        begin
            p.word.mask = MASK_ONE;
        end
        p.word.color = color_hold;
        p.done = done;
        pending_points.push_back(p);
    endtask

    // a start item's load or one midpoint step of the ellipse, decision values kept at four times scale
    task automatic step_ellipse(input logic kind, input logic [S_BITS-1:0] d);
        longint x, y;
        bit done;
        if (kind == KIND_START)
        begin
            org_x = longint'($signed(d[10:0]));
            org_y = longint'($signed(d[21:11]));
            a_sq = longint'(d[30:22]) * longint'(d[30:22]);
            b_sq = longint'(d[39:31]) * longint'(d[39:31]);
            axis_b = longint'(d[39:31]);
            cur_x = 0;
            cur_y = axis_b;
            dec_val = 4 * b_sq - 4 * a_sq * axis_b + a_sq;
            in_r2 = 1'b0;
            steps_taken = 0;
            step_cap = int'(d[49:40]);
            mirror_on = d[50];
            color_hold = d[82:51];
            done = trace_finished();
            tracing = !done;
            push_point(1'b1, done);
        end
        else if (tracing)
        begin
            x = cur_x;
            y = cur_y;
            steps_taken++;
            if (!in_r2 && a_sq * (2 * y - 1) > 2 * b_sq * (x + 1))
            begin
                if (dec_val < 0)
                    dec_val += 4 * b_sq * (2 * x + 3);
                else
                begin
                    dec_val += 4 * b_sq * (2 * x + 3) + 4 * a_sq * (2 - 2 * y);
                    cur_y--;
                end
                cur_x++;
            end
            else
            begin
                // region change re-seeds the decision on the same tick
                if (!in_r2)
                begin
                    in_r2 = 1'b1;
                    dec_val = b_sq * (2 * x + 1) * (2 * x + 1) + 4 * a_sq * (y - 1) * (y - 1)
                              - 4 * a_sq * axis_b * axis_b;
                end
                if (dec_val < 0)
                begin
                    dec_val += 4 * b_sq * (2 * x + 2) + 4 * a_sq * (3 - 2 * y);
                    cur_x++;
                end
                else
                    dec_val += 4 * a_sq * (3 - 2 * y);
                cur_y--;
            end
            done = trace_finished();
            tracing = !done;
            push_point(1'b0, done);
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        raster_point_t got;
        raster_point_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.word = m_tdata;
                got.done = m_tlast;
                if (pending_points.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_points.pop_front();
                    check_field("px0", 32'(want.word.px0), 32'(got.word.px0));
                    check_field("py0", 32'(want.word.py0), 32'(got.word.py0));
                    check_field("px1", 32'(want.word.px1), 32'(got.word.px1));
                    check_field("py1", 32'(want.word.py1), 32'(got.word.py1));
                    check_field("px2", 32'(want.word.px2), 32'(got.word.px2));
                    check_field("py2", 32'(want.word.py2), 32'(got.word.py2));
                    check_field("px3", 32'(want.word.px3), 32'(got.word.px3));
                    check_field("py3", 32'(want.word.py3), 32'(got.word.py3));
                    check_field("pixel_mask", 32'(want.word.mask), 32'(got.word.mask));
                    check_field("pixel_color", want.word.color, got.word.color);
                    check_field("pad", 32'(want.word.pad), 32'(got.word.pad));
                    check_field("done_res", 32'(want.done), 32'(got.done));
                end
            end
            if (s_tvalid && s_tready)
                step_ellipse(s_tuser, s_tdata);
        end
    end

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    int  stall_mode;
    int  mode_left;
    int  run_left;
    bit  run_val;
    bit [1:0] beat;
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            beat++;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (beat != 2'd3);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_left = $urandom_range(1, 8);
                        run_val = !run_val;
                    end
                    run_left--;
                    m_tready <= run_val;
                end
            endcase
        end
    end

    function automatic logic [S_BITS-1:0] pack_start(input logic signed [10:0] cx,
            input logic signed [10:0] cy, input logic [8:0] sa, input logic [8:0] sb,
            input logic [9:0] lim, input logic mir, input logic [31:0] col);
        return {5'd0, col, mir, lim, sb, sa, cy, cx};
    endfunction

    function automatic logic [S_BITS-1:0] tick_noise();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[S_BITS-1:0];
    endfunction

    task automatic send_item(input logic kind, input logic [S_BITS-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (kind == KIND_START || tracing)
            items_sent++;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic run_ellipse(input logic [S_BITS-1:0] start_word, input int max_ticks);
        int n;
        n = 0;
        send_item(KIND_START, start_word);
        while (tracing && n < max_ticks)
        begin
            send_item(KIND_TICK, tick_noise());
            n++;
        end
    endtask

    task automatic test_directed();
        gap_max = 3;
        send_item(KIND_TICK, tick_noise());             // nothing running yet
        run_ellipse(pack_start(11'sd0, 11'sd0, 9'd5, 9'd0, 10'd1023, 1'b1, 32'h12345678), 4);
        run_ellipse(pack_start(11'sd7, -11'sd7, 9'd7, 9'd4, 10'd0, 1'b1, 32'h0), 4);
        send_item(KIND_TICK, tick_noise());
        // widest ellipse at the corner of the coordinate range, dropped by a new start
        run_ellipse(pack_start(-11'sd1024, 11'sd1023, 9'd511, 9'd511, 10'd1023, 1'b1,
                               32'hFFFFFFFF), 4);
        // zero horizontal axis goes straight to region 2
        run_ellipse(pack_start(11'sd1023, -11'sd1024, 9'd0, 9'd3, 10'd1023, 1'b0, 32'h0), 8);
        run_ellipse(pack_start(11'sd100, -11'sd100, 9'd3, 9'd2, 10'd1023, 1'b1,
                               32'hA5A5A5A5), 8);
        // step limit cuts a long region 1 run
        run_ellipse(pack_start(-11'sd1, 11'sd1, 9'd511, 9'd1, 10'd3, 1'b1, 32'h5A5A5A5A), 8);
        send_item(KIND_TICK, tick_noise());
    endtask

    task automatic test_output_backpressure();
        gap_max = 0;
        hold_cycles = 300;
        run_ellipse(pack_start(11'sd30, 11'sd40, 9'd30, 9'd20, 10'd1023, 1'b1, $urandom), 30);
    endtask

    task automatic test_random_ellipses();
        int r;
        logic [8:0] sa, sb;
        logic [9:0] lim;
        int max_ticks;
        while (items_sent < 1450)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                sa = 9'($urandom_range(0, 24));
                sb = 9'($urandom_range(0, 24));
            end
            else if (r < 95)
            begin
                sa = 9'($urandom_range(0, 120));
                sb = 9'($urandom_range(0, 120));
            end
            else
            begin
                sa = 9'($urandom_range(0, 511));
                sb = 9'($urandom_range(0, 511));
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                lim = 10'd1023;
            else if (r < 80)
                lim = 10'($urandom_range(0, 1023));
            else
                lim = 10'($urandom_range(0, 8));
            // keep big ellipses short
            if ((sa > 120 || sb > 120) && lim > 160)
                lim = 10'($urandom_range(0, 160));
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if ($urandom_range(0, 49) == 0)
                hold_cycles = $urandom_range(60, 200);
            max_ticks = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 12) : 100000;
            run_ellipse(pack_start(11'($urandom), 11'($urandom), sa, sb, lim, 1'($urandom),
                                   $urandom), max_ticks);
            if ($urandom_range(0, 11) == 0)
                send_item(KIND_TICK, tick_noise());
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        gap_max = 0;
        hold_cycles = 0;
        tracing = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_output_backpressure();
        test_random_ellipses();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("midpoint_ellipse_raster_core: match");
        else
            $display("midpoint_ellipse_raster_core: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("midpoint_ellipse_raster_core: mismatch");
        $finish;
    end

endmodule
